// File: hw/rtl/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
`default_nettype none

package rbst_pkg;

  localparam int unsigned LANES   = 4;   // x min, x max, y min, y max slab parameters
  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIR_W   = 33;  // exact difference of two coordinates
  localparam int unsigned QUO_W   = 33;  // quotient bits kept before saturation

  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] ray_start_x;
    logic signed [COORD_W-1:0] ray_start_y;
    logic signed [COORD_W-1:0] ray_end_x;
    logic signed [COORD_W-1:0] ray_end_y;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
  } in_item_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] t_enter;
    logic signed [COORD_W-1:0] t_exit;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/rbst_div_cell.sv
// One cell of the divider chain: settles one quotient bit for all four lanes.
`default_nettype none

module rbst_div_cell #(
  parameter int unsigned NW  = 49,
  parameter int unsigned BIT = 0
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       valid_i,
  output logic                                      ready_o,
  input  wire  [rbst_pkg::LANES-1:0][NW-1:0]        rem_i,
  input  wire  [rbst_pkg::LANES-1:0][rbst_pkg::DIR_W-1:0] div_i,
  input  wire  [rbst_pkg::LANES-1:0][rbst_pkg::QUO_W-1:0] quo_i,
  input  wire  [rbst_pkg::LANES-1:0]                neg_i,
  input  wire  [rbst_pkg::LANES-1:0]                ovf_i,
  output logic                                      valid_o,
  input  wire                                       ready_i,
  output logic [rbst_pkg::LANES-1:0][NW-1:0]        rem_o,
  output logic [rbst_pkg::LANES-1:0][rbst_pkg::DIR_W-1:0] div_o,
  output logic [rbst_pkg::LANES-1:0][rbst_pkg::QUO_W-1:0] quo_o,
  output logic [rbst_pkg::LANES-1:0]                neg_o,
  output logic [rbst_pkg::LANES-1:0]                ovf_o
);
  import rbst_pkg::*;

  logic                             valid_q;
  logic [LANES-1:0][NW-1:0]         rem_d, rem_q;
  logic [LANES-1:0][QUO_W-1:0]      quo_d, quo_q;
  logic [LANES-1:0][DIR_W-1:0]      div_q;
  logic [LANES-1:0]                 neg_q, ovf_q;
  logic [LANES-1:0][NW-1:0]         hi;
  logic [LANES-1:0]                 take;

  // The remainder entering this cell is below div << (BIT+1), so one compare
  // and one subtract settle the bit.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      hi[l]    = rem_i[l] >> BIT;
      take[l]  = hi[l] >= NW'(div_i[l]);
      rem_d[l] = take[l] ? rem_i[l] - (NW'(div_i[l]) << BIT) : rem_i[l];
      quo_d[l] = quo_i[l];
      quo_d[l][BIT] = take[l];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      div_q <= div_i;
      neg_q <= neg_i;
      ovf_q <= ovf_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign neg_o   = neg_q;
  assign ovf_o   = ovf_q;

endmodule

`default_nettype wire

// File: hw/rtl/rbst_select.sv
// Saturation of the four slab parameters, then entry, exit and hit decision.
`default_nettype none

module rbst_select (
  input  wire                                             clk_i,
  input  wire                                             rst_ni,
  input  wire                                             valid_i,
  output logic                                            ready_o,
  input  wire  [rbst_pkg::LANES-1:0][rbst_pkg::QUO_W-1:0] quo_i,
  input  wire  [rbst_pkg::LANES-1:0]                      neg_i,
  input  wire  [rbst_pkg::LANES-1:0]                      ovf_i,
  output logic                                            out_valid_o,
  input  wire                                             out_stall_i,
  output rbst_pkg::out_item_t                             out_data_o
);
  import rbst_pkg::*;

  logic                                   s1_valid_q, s2_valid_q;
  logic                                   s1_ready, s2_ready;
  logic signed [LANES-1:0][COORD_W-1:0]   t_d, t_q;
  logic signed [COORD_W-1:0]              t_x0, t_x1, t_y0, t_y1;
  logic signed [COORD_W-1:0]              mn_x, mx_x, mn_y, mx_y, t_min, t_max;
  out_item_t                              res_d, res_q;
  logic                                   big;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      big = ovf_i[l] || quo_i[l][QUO_W-1] || quo_i[l][COORD_W-1];
      if (neg_i[l]) begin
        t_d[l] = big ? Q_MIN : -$signed({1'b0, quo_i[l][COORD_W-2:0]});
      end else begin
        t_d[l] = big ? Q_MAX : $signed({1'b0, quo_i[l][COORD_W-2:0]});
      end
    end
  end

  // Elements of a packed array read back unsigned, so each lane is taken
  // into a signed word before the comparisons.
  always_comb begin
    t_x0  = $signed(t_q[0]);
    t_x1  = $signed(t_q[1]);
    t_y0  = $signed(t_q[2]);
    t_y1  = $signed(t_q[3]);
    mn_x  = (t_x0 < t_x1) ? t_x0 : t_x1;
    mx_x  = (t_x0 > t_x1) ? t_x0 : t_x1;
    mn_y  = (t_y0 < t_y1) ? t_y0 : t_y1;
    mx_y  = (t_y0 > t_y1) ? t_y0 : t_y1;
    t_min = (mn_x > mn_y) ? mn_x : mn_y;
    t_max = (mx_x < mx_y) ? mx_x : mx_y;
    res_d.t_enter = t_min;
    res_d.t_exit  = t_max;
    res_d.hit     = !(t_max < 0 || t_min > t_max);
  end

  assign s2_ready = !s2_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) t_q <= t_d;
    if (s2_ready) res_q <= res_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// File: hw/rtl/ray_box_slab_test.sv
// Top level of the 2D ray segment versus axis-aligned box slab test.
`default_nettype none

// Takes one segment and box per cycle while in_stall_o is low and returns
// entry and exit parameters with a hit flag. An item passes one operand
// stage, a chain of 33 divider cells (one quotient bit per cell for all four
// slab divisions) and two selection stages.
// Every stage holds its item under output stall and bubbles close up, so a
// new transfer is taken while a finished result still waits downstream.
module ray_box_slab_test #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  rbst_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output rbst_pkg::out_item_t  out_data_o
);
  import rbst_pkg::*;

  localparam int unsigned NW = DIR_W + FRAC_BITS;

  // Operand stage
  logic                                a_valid_q, a_ready;
  logic signed [LANES-1:0][DIR_W-1:0]  num_d, num_q;
  logic signed [1:0][DIR_W-1:0]        dir_d, dir_q;
  logic signed [DIR_W-1:0]             dx, dy;

  always_comb begin
    dx = DIR_W'(in_data_i.ray_end_x) - DIR_W'(in_data_i.ray_start_x);
    dy = DIR_W'(in_data_i.ray_end_y) - DIR_W'(in_data_i.ray_start_y);
    dir_d[0] = (dx == '0) ? DIR_W'(1) : dx;
    dir_d[1] = (dy == '0) ? DIR_W'(1) : dy;
    num_d[0] = DIR_W'(in_data_i.box_min_x) - DIR_W'(in_data_i.ray_start_x);
    num_d[1] = DIR_W'(in_data_i.box_max_x) - DIR_W'(in_data_i.ray_start_x);
    num_d[2] = DIR_W'(in_data_i.box_min_y) - DIR_W'(in_data_i.ray_start_y);
    num_d[3] = DIR_W'(in_data_i.box_max_y) - DIR_W'(in_data_i.ray_start_y);
  end

  // Chain wiring: index QUO_W feeds the top cell, index 0 leaves the last one.
  logic [QUO_W:0]                           c_valid, c_ready;
  logic [QUO_W:0][LANES-1:0][NW-1:0]        c_rem;
  logic [QUO_W:0][LANES-1:0][DIR_W-1:0]     c_div;
  logic [QUO_W:0][LANES-1:0][QUO_W-1:0]     c_quo;
  logic [QUO_W:0][LANES-1:0]                c_neg, c_ovf;
  logic [LANES-1:0][DIR_W-1:0]              num_mag;
  logic [LANES-1:0][DIR_W-1:0]              div_mag;
  logic [LANES-1:0][NW-1:0]                 head_rem;
  logic [LANES-1:0]                         head_neg, head_ovf;

  assign a_ready    = !a_valid_q || c_ready[QUO_W];
  assign in_stall_o = !a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      num_q <= num_d;
      dir_q <= dir_d;
    end
  end

  // Magnitudes and signs; a quotient of 2^33 or more is flagged up front so
  // the cells only need to resolve the low 33 bits.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_mag[l]  = num_q[l][DIR_W-1] ? -num_q[l] : num_q[l];
      div_mag[l]  = dir_q[l/2][DIR_W-1] ? -dir_q[l/2] : dir_q[l/2];
      head_rem[l] = NW'(num_mag[l]) << FRAC_BITS;
      head_neg[l] = num_q[l][DIR_W-1] ^ dir_q[l/2][DIR_W-1];
      head_ovf[l] = (NW'(num_mag[l]) >> (QUO_W - FRAC_BITS)) >= NW'(div_mag[l]);
    end
  end
  assign c_valid[QUO_W] = a_valid_q;
  assign c_rem[QUO_W]   = head_rem;
  assign c_div[QUO_W]   = div_mag;
  assign c_quo[QUO_W]   = '0;
  assign c_neg[QUO_W]   = head_neg;
  assign c_ovf[QUO_W]   = head_ovf;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    rbst_div_cell #(
      .NW  (NW),
      .BIT (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_valid[k+1]),
      .ready_o (c_ready[k+1]),
      .rem_i   (c_rem[k+1]),
      .div_i   (c_div[k+1]),
      .quo_i   (c_quo[k+1]),
      .neg_i   (c_neg[k+1]),
      .ovf_i   (c_ovf[k+1]),
      .valid_o (c_valid[k]),
      .ready_i (c_ready[k]),
      .rem_o   (c_rem[k]),
      .div_o   (c_div[k]),
      .quo_o   (c_quo[k]),
      .neg_o   (c_neg[k]),
      .ovf_o   (c_ovf[k])
    );
  end

  rbst_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (c_valid[0]),
    .ready_o     (c_ready[0]),
    .quo_i       (c_quo[0]),
    .neg_i       (c_neg[0]),
    .ovf_i       (c_ovf[0]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A hit always has a nonnegative exit at or after the entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.t_enter <= out_data_o.t_exit)
    else $error("hit reported with entry after exit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> !out_data_o.t_exit[COORD_W-1])
    else $error("hit reported with negative exit");

  // Input stall only when the operand stage holds an item that cannot move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid_q && !c_ready[QUO_W])
    else $error("input stalled with room in the operand stage");

endmodule

`default_nettype wire
